// ----- rtl/core/aspm_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the column substitution function of the permutation
// no dependencies
package aspm_pkg;

   localparam int WORD_W         = 64;
   localparam int NUM_WORDS      = 5;
   localparam int RC_W           = 4;
   localparam int MAX_ROUNDS_DEF = 15;
   localparam int CNT_W          = 6;

   // right rotation amounts of the linear layer, one pair per word
   localparam int ROT_A [NUM_WORDS] = '{19, 61, 1, 10, 7};
   localparam int ROT_B [NUM_WORDS] = '{28, 39, 6, 17, 41};

   typedef struct packed {
      logic [WORD_W-1:0] in_word0;
      logic [WORD_W-1:0] in_word1;
      logic [WORD_W-1:0] in_word2;
      logic [WORD_W-1:0] in_word3;
      logic [WORD_W-1:0] in_word4;
      logic [RC_W-1:0]   round_count;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word0;
      logic [WORD_W-1:0] out_word1;
      logic [WORD_W-1:0] out_word2;
      logic [WORD_W-1:0] out_word3;
      logic [WORD_W-1:0] out_word4;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic capture;
   } ctrl_type;

   // 5-bit substitution on one bit column, bit k taken from word k
   function automatic logic [NUM_WORDS-1:0] sbox(input logic [NUM_WORDS-1:0] x);
      logic a, b, c, d, e;
      logic [NUM_WORDS-1:0] y;
      a = x[0];
      b = x[1];
      c = x[2];
      d = x[3];
      e = x[4];
      y[0] = (e & b) ^ d ^ (c & b) ^ c ^ (b & a) ^ b ^ a;
      y[1] = e ^ (d & c) ^ (d & b) ^ d ^ (c & b) ^ c ^ b ^ a;
      y[2] = ~((e & d) ^ e ^ c ^ b);
      y[3] = (e & a) ^ e ^ (d & a) ^ d ^ c ^ b ^ a;
      y[4] = (e & b) ^ e ^ d ^ (b & a) ^ b;
      return y;
   endfunction

endpackage

// ----- rtl/core/aspm_cell.sv -----
`timescale 1ns / 1ps
// one bit column of the state: holds five bits, one per word, and runs the sbox
// depends on aspm_pkg
module aspm_cell (
   input  logic                             clock,
   input  aspm_pkg::ctrl_type               ctl,
   input  logic [aspm_pkg::NUM_WORDS-1:0]   load_col,
   input  logic [aspm_pkg::NUM_WORDS-1:0]   mix_a,
   input  logic [aspm_pkg::NUM_WORDS-1:0]   mix_b,
   output logic [aspm_pkg::NUM_WORDS-1:0]   col,
   output logic [aspm_pkg::NUM_WORDS-1:0]   sb
);
   import aspm_pkg::*;

   logic [NUM_WORDS-1:0] col_ff;
   logic [NUM_WORDS-1:0] col_in;

   assign sb  = sbox(col_ff);
   assign col = col_ff;

   // linear layer: own sbox bit xor the two rotated partners' bits
   always_comb begin
      col_in = col_ff;
      if (ctl.load) begin
         col_in = load_col;
      end else if (ctl.step) begin
         col_in = sb ^ mix_a ^ mix_b;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

endmodule

// ----- rtl/core/aspm_ctrl.sv -----
`timescale 1ns / 1ps
// round sequencer: takes a transaction, counts rounds, hands the state to the output
// depends on aspm_pkg
module aspm_ctrl #(
   parameter int MAX_ROUNDS = aspm_pkg::MAX_ROUNDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [aspm_pkg::RC_W-1:0]   round_count,
   input  logic                        out_free,
   output logic                        req_ready,
   output aspm_pkg::ctrl_type          ctl
);
   import aspm_pkg::*;

   state_type          state_ff, state_in;
   logic [RC_W-1:0]    cnt_ff, cnt_in;
   logic [RC_W-1:0]    rounds_sat;

   // saturate the requested count at the build limit
   always_comb begin
      if ({{(CNT_W-RC_W){1'b0}}, round_count} > CNT_W'(MAX_ROUNDS)) begin
         rounds_sat = RC_W'(MAX_ROUNDS);
      end else begin
         rounds_sat = round_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_ready   = 1'b0;
      ctl         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               cnt_in   = rounds_sat;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) begin
               ctl.step = 1'b1;
               cnt_in   = cnt_ff - RC_W'(1);
            end else if (out_free) begin
               ctl.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_step_needs_rounds: assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> (state_ff == ST_RUN) && (cnt_ff != '0))
      else $error("round step with no rounds left");

   a_step_counts_down: assert property (@(posedge clock) disable iff (reset)
      ctl.step |=> cnt_ff == $past(cnt_ff) - RC_W'(1))
      else $error("round counter did not count down");

   a_capture_frees: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after handing off result");

   a_load_runs: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (state_ff == ST_RUN))
      else $error("loaded transaction not running");

endmodule

// ----- rtl/core/ascon_style_permutation.sv -----
`timescale 1ns / 1ps
// top level of the constant-free 320-bit permutation: cell row, sequencer, output register
// depends on aspm_pkg, aspm_cell, aspm_ctrl
//
// One transaction carries five 64-bit state words and a round count; the result is
// the state after that many rounds of sbox plus linear diffusion, with no round
// constants. A count of zero returns the state unchanged, and a count above
// MAX_ROUNDS is held at MAX_ROUNDS. The state lives in a row of 64 identical
// cells, one per bit column; on each round step every cell runs its sbox and takes the
// rotated sbox bits of its partner cells, so one full round completes per clock.
// A transaction holds the row through the load, its round steps and the hand-off
// to the output register, which waits until that register is free. Only one
// transaction is in the row at a time; the output register lets the next
// transaction start while the previous result still waits on rsp_ready.
module ascon_style_permutation #(
   parameter int MAX_ROUNDS = aspm_pkg::MAX_ROUNDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aspm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aspm_pkg::rsp_type rsp_data
);
   import aspm_pkg::*;

   ctrl_type             ctl;
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // word view of the incoming state and the cell outputs
   logic [WORD_W-1:0]    in_words   [NUM_WORDS];
   logic [WORD_W-1:0]    cell_words [NUM_WORDS];
   logic [NUM_WORDS-1:0] col_w      [WORD_W];
   logic [NUM_WORDS-1:0] sb_w       [WORD_W];

   assign in_words[0] = req_data.in_word0;
   assign in_words[1] = req_data.in_word1;
   assign in_words[2] = req_data.in_word2;
   assign in_words[3] = req_data.in_word3;
   assign in_words[4] = req_data.in_word4;

   // the output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   aspm_ctrl #(
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .round_count (req_data.round_count),
      .out_free    (out_free),
      .req_ready   (req_ready),
      .ctl         (ctl)
   );

   // row of column cells; partners for word k sit ROT_A[k] and ROT_B[k] places up
   for (genvar i = 0; i < WORD_W; i++) begin : g_cell
      logic [NUM_WORDS-1:0] load_col;
      logic [NUM_WORDS-1:0] mix_a;
      logic [NUM_WORDS-1:0] mix_b;

      for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
         assign load_col[k]      = in_words[k][i];
         assign mix_a[k]         = sb_w[(i + ROT_A[k]) % WORD_W][k];
         assign mix_b[k]         = sb_w[(i + ROT_B[k]) % WORD_W][k];
         assign cell_words[k][i] = col_w[i][k];
      end

      aspm_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_col (load_col),
         .mix_a    (mix_a),
         .mix_b    (mix_b),
         .col      (col_w[i]),
         .sb       (sb_w[i])
      );
   end

   // finished state goes to the output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.capture) begin
         rsp_data_in.out_word0 = cell_words[0];
         rsp_data_in.out_word1 = cell_words[1];
         rsp_data_in.out_word2 = cell_words[2];
         rsp_data_in.out_word3 = cell_words[3];
         rsp_data_in.out_word4 = cell_words[4];
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_capture_only_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |-> out_free)
      else $error("result handed off over a pending one");

   a_capture_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> rsp_valid)
      else $error("handed-off result not presented");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (ctl.step || ctl.capture) |-> !req_ready)
      else $error("transaction accepted while the row is busy");

endmodule
